FILE: hw/rtl/rlebd_pkg.sv
// Shared types and constants for the run-length BGRA row decoder.
// No dependencies.
package rlebd_pkg;

  localparam int LEN_W         = 13;
  // widest row; must fit LEN_W
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = 2;

  localparam logic [2:0] METH_LIT3 = 3'd2;
  localparam logic [2:0] METH_REP3 = 3'd3;
  localparam logic [2:0] METH_LIT4 = 3'd4;
  localparam logic [2:0] METH_REP4 = 3'd5;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [8:0] {
    PH_CMD_LO = 9'b000000001,
    PH_CMD_HI = 9'b000000010,
    PH_SKIP   = 9'b000000100,
    PH_COUNT  = 9'b000001000,
    PH_LIT3   = 9'b000010000,
    PH_LIT4   = 9'b000100000,
    PH_REP3   = 9'b001000000,
    PH_REP4   = 9'b010000000,
    PH_DRAIN  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [7:0]       alpha;
    logic [LEN_W-1:0] run_length;
    logic             row_done;
    logic             truncated;
  } result_t;

  // Runs produced by one parse step: the command's own run and the short-stream pad.
  typedef struct packed {
    logic main;
    logic pad;
  } emit_t;

endpackage

FILE: hw/rtl/rle_bgra_row_decoder_unit.sv
// Run-length BGRA row decoder, top level: input register, parser, result queue.
// Depends on rlebd_pkg, rlebd_parser, rlebd_res_fifo.
//
// Takes one byte of a compressed row stream per cycle and produces runs of
// identical BGRA pixels. An item is held in the input register, parsed by
// combinational logic and its runs land in a four-entry result queue that
// drives the outputs. One byte per cycle is sustained as long as the result
// queue has room for two runs, so the output side (one run per cycle while
// out_stall is low) sets the limit when bytes produce runs faster than they
// are taken. A byte flagged as stream end that leaves the row short produces
// an extra zero-pixel run filling the row, flagged truncated. row_width
// may only be written while the block is idle; a write restarts the row.
module rle_bgra_row_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          stream_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    blue,
  output logic [7:0]                    green,
  output logic [7:0]                    red,
  output logic [7:0]                    alpha,
  output logic [rlebd_pkg::LEN_W-1:0]   run_length,
  output logic                          row_done,
  output logic                          truncated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rlebd_pkg::LEN_W-1:0]   row_width
);
  import rlebd_pkg::*;

  logic               held;
  logic [7:0]         byte_q;
  logic               end_q;
  logic               room, step, accept;
  emit_t              emit;
  result_t            res_main, res_pad, d0, d1, head;
  logic [1:0]         push_n;
  logic [FIFO_AW:0]   count;

  assign room     = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign step     = held && room;
  assign in_stall = held && !room;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = !held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= data_byte;
      end_q  <= stream_end;
    end
  end

  rlebd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (byte_q),
    .stream_end (end_q),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_width  (row_width),
    .emit       (emit),
    .res_main   (res_main),
    .res_pad    (res_pad)
  );

  // pack the step's runs into consecutive queue slots
  always_comb begin
    d0 = res_main;
    d1 = res_pad;
    push_n = 2'd0;
    priority if (emit.main && emit.pad) begin
      push_n = 2'd2;
    end else if (emit.main) begin
      push_n = 2'd1;
    end else if (emit.pad) begin
      d0 = res_pad;
      push_n = 2'd1;
    end else begin
      push_n = 2'd0;
    end
  end

  rlebd_res_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .d0     (d0),
    .d1     (d1),
    .pop    (!out_stall),
    .dout   (head),
    .count  (count)
  );

  assign out_valid  = (count != '0);
  assign blue       = head.blue;
  assign green      = head.green;
  assign red        = head.red;
  assign alpha      = head.alpha;
  assign run_length = head.run_length;
  assign row_done   = head.row_done;
  assign truncated  = head.truncated;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pad_on_end: assert property (@(posedge clk) disable iff (rst)
    emit.pad |-> (step && end_q))
    else $error("pad run without stream end");

  a_one_row_done: assert property (@(posedge clk) disable iff (rst)
    (emit.main && emit.pad) |-> !res_main.row_done)
    else $error("row completed twice in one step");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> ($past(count) <= (FIFO_AW + 1)'(FIFO_DEPTH)) && room)
    else $error("push without room");

endmodule

FILE: hw/rtl/rlebd_parser.sv
// Byte parser: command words, counts, pixel groups and row bookkeeping.
// Depends on rlebd_pkg.
module rlebd_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [7:0]                      data_byte,
  input  logic                            stream_end,
  input  logic                            cfg_write,
  input  logic [rlebd_pkg::LEN_W-1:0]     cfg_width,
  output rlebd_pkg::emit_t                emit,
  output rlebd_pkg::result_t              res_main,
  output rlebd_pkg::result_t              res_pad
);
  import rlebd_pkg::*;

  phase_t            phase, phase_next;
  logic              stream_parity, stream_parity_next;
  logic [7:0]        cmd_lo, cmd_lo_next;
  logic [2:0]        method, method_next;
  logic [1:0]        skip_left, skip_left_next;
  logic [31:0]       run_count, run_count_next;
  logic [LEN_W-1:0]  pixels_left, pixels_left_next;
  logic [31:0]       pixel_bytes, pixel_bytes_next;
  logic [2:0]        byte_in_group, byte_in_group_next;
  logic [LEN_W-1:0]  cur_width;

  logic              hdr, data, em_main, em_pad, three;
  logic [LEN_W-1:0]  len_req, len_c;
  logic [31:0]       pix_v;
  logic [31:0]       byte_sh;
  result_t           rm, rp;

  function automatic logic [LEN_W-1:0] eff_width(input logic [LEN_W-1:0] w);
    logic [LEN_W-1:0] r;
    r = w;
    if (w == '0) r = LEN_W'(1);
    if (32'(w) > 32'(MAX_ROW_WIDTH)) r = LEN_W'(MAX_ROW_WIDTH);
    return r;
  endfunction

  always_comb begin
    phase_next         = phase;
    stream_parity_next = ~stream_parity;
    cmd_lo_next        = cmd_lo;
    method_next        = method;
    skip_left_next     = skip_left;
    run_count_next     = run_count;
    pixels_left_next   = pixels_left;
    pixel_bytes_next   = pixel_bytes;
    byte_in_group_next = byte_in_group;
    hdr     = 1'b0;
    data    = 1'b0;
    em_main = 1'b0;
    em_pad  = 1'b0;
    three   = 1'b0;
    len_req = '0;
    len_c   = '0;
    rm      = '0;
    rp      = '0;
    byte_sh = {24'b0, data_byte} << {byte_in_group[1:0], 3'b000};
    pix_v   = pixel_bytes | byte_sh;

    unique case (phase)
      PH_CMD_LO: begin
        // a command starts on an even position; odd byte is a pad
        if (!stream_parity) begin
          cmd_lo_next = data_byte;
          phase_next  = PH_CMD_HI;
        end
      end
      PH_CMD_HI: begin
        method_next    = data_byte[7:5];
        skip_left_next = data_byte[4:3];
        run_count_next = {21'b0, data_byte[2:0], cmd_lo};
        hdr = 1'b1;
      end
      PH_SKIP: begin
        skip_left_next = skip_left - 2'd1;
        hdr = 1'b1;
      end
      PH_COUNT: begin
        run_count_next     = run_count | byte_sh;
        byte_in_group_next = byte_in_group + 3'd1;
        data = byte_in_group_next[2];
      end
      PH_LIT3, PH_LIT4, PH_REP3, PH_REP4: begin
        three = (phase == PH_LIT3) || (phase == PH_REP3);
        pixel_bytes_next   = pix_v;
        byte_in_group_next = byte_in_group + 3'd1;
        if (three ? (byte_in_group_next == 3'd3) : (byte_in_group_next == 3'd4)) begin
          pixel_bytes_next   = '0;
          byte_in_group_next = '0;
          if (three) begin
            rm.blue  = pix_v[7:0];
            rm.green = pix_v[15:8];
            rm.red   = pix_v[23:16];
            rm.alpha = ALPHA_OPAQUE;
          end else begin
            rm.blue  = pix_v[15:8];
            rm.green = pix_v[23:16];
            rm.red   = pix_v[31:24];
            rm.alpha = pix_v[7:0];
          end
          if (phase == PH_LIT3 || phase == PH_LIT4) begin
            em_main = 1'b1;
            len_req = LEN_W'(1);
            run_count_next = run_count - 32'(run_count != '0);
            if (run_count_next == '0) phase_next = PH_CMD_LO;
          end else begin
            em_main = (run_count != '0);
            len_req = run_count[LEN_W-1:0];
            run_count_next = '0;
            phase_next = PH_CMD_LO;
          end
        end
      end
      default: ;
    endcase

    if (hdr) begin
      priority if (skip_left_next != '0) begin
        phase_next = PH_SKIP;
      end else if (run_count_next[10:0] == '0) begin
        // zero count field: a 32-bit count follows
        run_count_next     = '0;
        byte_in_group_next = '0;
        phase_next         = PH_COUNT;
      end else begin
        data = 1'b1;
      end
    end

    if (data) begin
      if (run_count_next > 32'(pixels_left)) run_count_next = 32'(pixels_left);
      pixel_bytes_next   = '0;
      byte_in_group_next = '0;
      unique case (method_next)
        METH_LIT3: phase_next = (run_count_next != '0) ? PH_LIT3 : PH_CMD_LO;
        METH_REP3: phase_next = PH_REP3;
        METH_LIT4: phase_next = (run_count_next != '0) ? PH_LIT4 : PH_CMD_LO;
        METH_REP4: phase_next = PH_REP4;
        default: begin
          phase_next = PH_CMD_LO;
          em_main    = (run_count_next != '0);
          len_req    = run_count_next[LEN_W-1:0];
        end
      endcase
    end

    if (em_main) begin
      len_c = (len_req > pixels_left) ? pixels_left : len_req;
      pixels_left_next = pixels_left - len_c;
      rm.run_length = len_c;
      rm.row_done   = (pixels_left_next == '0);
      if (pixels_left_next == '0) phase_next = PH_DRAIN;
    end

    if (stream_end) begin
      if (phase_next != PH_DRAIN && pixels_left_next != '0) begin
        em_pad        = 1'b1;
        rp.run_length = pixels_left_next;
        rp.row_done   = 1'b1;
        rp.truncated  = 1'b1;
      end
      phase_next         = PH_CMD_LO;
      stream_parity_next = 1'b0;
      cmd_lo_next        = '0;
      method_next        = '0;
      skip_left_next     = '0;
      run_count_next     = '0;
      pixels_left_next   = eff_width(cur_width);
      pixel_bytes_next   = '0;
      byte_in_group_next = '0;
    end
  end

  assign emit.main = step && em_main;
  assign emit.pad  = step && em_pad;
  assign res_main  = rm;
  assign res_pad   = rp;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      cur_width     <= rst ? LEN_W'(MAX_ROW_WIDTH) : cfg_width;
      pixels_left   <= eff_width(rst ? LEN_W'(MAX_ROW_WIDTH) : cfg_width);
      phase         <= PH_CMD_LO;
      stream_parity <= 1'b0;
      cmd_lo        <= '0;
      method        <= '0;
      skip_left     <= '0;
      run_count     <= '0;
      pixel_bytes   <= '0;
      byte_in_group <= '0;
    end else if (step) begin
      phase         <= phase_next;
      stream_parity <= stream_parity_next;
      cmd_lo        <= cmd_lo_next;
      method        <= method_next;
      skip_left     <= skip_left_next;
      run_count     <= run_count_next;
      pixels_left   <= pixels_left_next;
      pixel_bytes   <= pixel_bytes_next;
      byte_in_group <= byte_in_group_next;
    end
  end

endmodule

FILE: hw/rtl/rlebd_res_fifo.sv
// Result queue: up to two runs written per cycle, one read per cycle while pop is asserted.
// Depends on rlebd_pkg.
module rlebd_res_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        push_n,
  input  rlebd_pkg::result_t                d0,
  input  rlebd_pkg::result_t                d1,
  input  logic                              pop,
  output rlebd_pkg::result_t                dout,
  output logic [rlebd_pkg::FIFO_AW:0]       count
);
  import rlebd_pkg::*;

  result_t            slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic               do_pop;

  assign do_pop = pop && (count != '0);
  assign dout   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) slots[wptr] <= d0;
    if (push_n == 2'd2) slots[wptr + FIFO_AW'(1)] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + FIFO_AW'(push_n);
      rptr  <= rptr + FIFO_AW'(do_pop);
      count <= count + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(do_pop);
    end
  end

endmodule
